### hdl/ebcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebcc_pkg
// Types and constants shared by the event builder consistency check blocks.
// ----------------------------------------------------------------------------
package ebcc_pkg;

    localparam int MASK_W   = 32;
    localparam int SRC_W    = 5;
    localparam int HANDLE_W = 16;
    localparam int TYPE_W   = 16;
    localparam int NUM_W    = 32;
    localparam int STAMP_W  = 16;
    localparam int MODE_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int MAX_RES  = 3;
    localparam int CNT_W    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BUILD_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SOURCES = 1'b1;

    // build mode bits
    localparam int MODE_MARKERS = 0;
    localparam int MODE_NUMBER  = 1;
    localparam int MODE_EXACT   = 2;
    localparam int MODE_NEAR    = 3;

    // request kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        RK_START  = 2'd0,
        RK_PASS   = 2'd1,
        RK_END    = 2'd2,
        RK_REJECT = 2'd3
    } rkind_t;

    typedef struct packed {
        logic                kind;
        logic [SRC_W-1:0]    source;
        logic [HANDLE_W-1:0] frame_handle;
        logic                end_of_event;
        logic [TYPE_W-1:0]   hdr_type;
        logic [NUM_W-1:0]    event_number;
        logic [STAMP_W-1:0]  stamp_high;
        logic [STAMP_W-1:0]  stamp_mid;
        logic [STAMP_W-1:0]  stamp_low;
    } frame_t;

    typedef struct packed {
        rkind_t              result_kind;
        logic [SRC_W-1:0]    out_source;
        logic [HANDLE_W-1:0] out_handle;
        logic                mismatch;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]          count;
        result_t [MAX_RES-1:0]     items;
    } res_batch_t;

endpackage
`default_nettype wire

### hdl/ebcc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebcc interfaces
// Valid/ready channels for frame requests and result items.
// ----------------------------------------------------------------------------
interface ebcc_frame_if;
    logic            valid;
    logic            ready;
    ebcc_pkg::frame_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ebcc_result_if;
    logic             valid;
    logic             ready;
    ebcc_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/event_builder_consistency_check_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// event_builder_consistency_check_unit
// Builds events from source frames and checks frame headers per event.
// ----------------------------------------------------------------------------
// frames: valid/ready request channel, one frame or flush request per item
// results: valid/ready channel, one result item per transfer, last flag
//   marks the final result of a request
// cfg_we/cfg_index/cfg_data: register writes, build_mode and active_sources
// a request is taken in the cycle it is offered when the result queue is
//   empty or holds one result that leaves in that cycle
// its first result shows on the next cycle; a request gives one to three
//   results (start marker, frame, end marker) leaving one per cycle while
//   the receiver is ready, so with a ready receiver plain frames go at one
//   request per cycle, and a request with markers holds off the next until
//   only its last result is left, set by the single output port of the queue
// a flush request gives no result; reset clears event state, registers and the result queue
// a stalled receiver holds the queued results and blocks new requests while
//   any result is waiting
// ----------------------------------------------------------------------------
module event_builder_consistency_check_unit #(
    parameter int NUM_SOURCES = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    ebcc_frame_if.sink                              frames,
    ebcc_result_if.source                           results,
    input  wire logic                               cfg_we,
    input  wire logic [ebcc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ebcc_pkg::MASK_W-1:0]        cfg_data
);

    logic [ebcc_pkg::MODE_W-1:0] build_mode_reg;
    logic [ebcc_pkg::MASK_W-1:0] active_reg;
    logic                        can_take;
    logic                        accept;
    ebcc_pkg::res_batch_t        batch;

    assign frames.ready = can_take;
    assign accept       = frames.valid && can_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            build_mode_reg <= '0;
            active_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ebcc_pkg::CFG_BUILD_MODE:
                    build_mode_reg <= cfg_data[ebcc_pkg::MODE_W-1:0];
                ebcc_pkg::CFG_ACTIVE_SOURCES:
                    active_reg <= cfg_data;
                default:
                    active_reg <= active_reg;
            endcase
        end
    end

    ebcc_core #(
        .NUM_SOURCES(NUM_SOURCES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .frame          (frames.payload),
        .build_mode     (build_mode_reg),
        .active_sources (active_reg),
        .batch          (batch)
    );

    ebcc_result_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .batch    (batch),
        .can_take (can_take),
        .results  (results)
    );

endmodule
`default_nettype wire

### hdl/ebcc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebcc_core
// Event state, header check and result generation for one request.
// ----------------------------------------------------------------------------
module ebcc_core #(
    parameter int NUM_SOURCES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire ebcc_pkg::frame_t              frame,
    input  wire logic [ebcc_pkg::MODE_W-1:0]   build_mode,
    input  wire logic [ebcc_pkg::MASK_W-1:0]   active_sources,
    output ebcc_pkg::res_batch_t               batch
);

    localparam logic [ebcc_pkg::MASK_W:0] ONE_WIDE = {{ebcc_pkg::MASK_W{1'b0}}, 1'b1};
    localparam logic [ebcc_pkg::MASK_W:0] MASK_WIDE = (ONE_WIDE << NUM_SOURCES) - ONE_WIDE;
    localparam logic [ebcc_pkg::MASK_W-1:0] SRC_MASK = MASK_WIDE[ebcc_pkg::MASK_W-1:0];

    logic [ebcc_pkg::MASK_W-1:0]   pending_reg, pending_next;
    logic                          started_reg, started_next;
    logic [ebcc_pkg::MASK_W-1:0]   seen_reg, seen_next;
    logic [ebcc_pkg::TYPE_W-1:0]   ref_type_reg;
    logic [ebcc_pkg::NUM_W-1:0]    ref_number_reg;
    logic [ebcc_pkg::STAMP_W-1:0]  ref_high_reg;
    logic [ebcc_pkg::STAMP_W-1:0]  ref_mid_reg;
    logic [ebcc_pkg::STAMP_W-1:0]  ref_low_reg;

    logic [ebcc_pkg::MASK_W-1:0]   pend_eff;
    logic [ebcc_pkg::MASK_W-1:0]   src_bit;
    logic [ebcc_pkg::MASK_W-1:0]   pend_after;
    logic [2*ebcc_pkg::STAMP_W-1:0] stamp_m, stamp_rm, stamp_inc, stamp_dec;
    logic                          is_flush, reject, do_check, is_ref;
    logic                          emit_start, emit_end;
    logic                          mis_num, mis_exact, mis_near, mis;

    function automatic ebcc_pkg::result_t make_res(
        ebcc_pkg::rkind_t                k,
        logic [ebcc_pkg::SRC_W-1:0]      s,
        logic [ebcc_pkg::HANDLE_W-1:0]   h,
        logic                            m,
        logic                            l
    );
        ebcc_pkg::result_t r;
        r.result_kind = k;
        r.out_source  = s;
        r.out_handle  = h;
        r.mismatch    = m;
        r.last        = l;
        return r;
    endfunction

    always_comb
    begin
        is_flush = (frame.kind == ebcc_pkg::KIND_FLUSH);
        pend_eff = (pending_reg == '0) ? (active_sources & SRC_MASK) : pending_reg;
        src_bit  = {{(ebcc_pkg::MASK_W-1){1'b0}}, 1'b1} << frame.source;
        reject   = !pend_eff[frame.source];
        do_check = (build_mode[ebcc_pkg::MODE_NEAR:ebcc_pkg::MODE_NUMBER] != '0)
                   && !seen_reg[frame.source];
        is_ref   = (seen_reg == '0);

        stamp_m   = {frame.stamp_mid, frame.stamp_low};
        stamp_rm  = {ref_mid_reg, ref_low_reg};
        stamp_inc = stamp_m + 32'd1;
        stamp_dec = stamp_m - 32'd1;

        mis_num   = build_mode[ebcc_pkg::MODE_NUMBER]
                    && (ref_type_reg != frame.hdr_type
                        || ref_number_reg != frame.event_number);
        mis_exact = build_mode[ebcc_pkg::MODE_EXACT]
                    && (ref_high_reg != frame.stamp_high || stamp_rm != stamp_m);
        mis_near  = build_mode[ebcc_pkg::MODE_NEAR]
                    && ((ref_high_reg != frame.stamp_high && stamp_m != '0
                         && stamp_m != '1)
                        || (stamp_rm != stamp_m && stamp_rm != stamp_inc
                            && stamp_rm != stamp_dec));
        mis = do_check && !is_ref && (mis_num || mis_exact || mis_near);

        emit_start = build_mode[ebcc_pkg::MODE_MARKERS] && !started_reg;
        pend_after = frame.end_of_event ? (pend_eff & ~src_bit) : pend_eff;
        emit_end   = build_mode[ebcc_pkg::MODE_MARKERS] && (pend_after == '0);
    end

    // result list
    always_comb
    begin
        batch.count = '0;
        batch.items = '0;
        if (is_flush)
        begin
            batch.count = '0;
        end
        else if (reject)
        begin
            batch.count    = 2'd1;
            batch.items[0] = make_res(ebcc_pkg::RK_REJECT, frame.source,
                                      frame.frame_handle, 1'b0, 1'b1);
        end
        else
        begin
            unique case ({emit_start, emit_end})
                2'b00:
                begin
                    batch.count    = 2'd1;
                    batch.items[0] = make_res(ebcc_pkg::RK_PASS, frame.source,
                                              frame.frame_handle, mis, 1'b1);
                end
                2'b10:
                begin
                    batch.count    = 2'd2;
                    batch.items[0] = make_res(ebcc_pkg::RK_START, '0, '0, 1'b0, 1'b0);
                    batch.items[1] = make_res(ebcc_pkg::RK_PASS, frame.source,
                                              frame.frame_handle, mis, 1'b1);
                end
                2'b01:
                begin
                    batch.count    = 2'd2;
                    batch.items[0] = make_res(ebcc_pkg::RK_PASS, frame.source,
                                              frame.frame_handle, mis, 1'b0);
                    batch.items[1] = make_res(ebcc_pkg::RK_END, '0, '0, 1'b0, 1'b1);
                end
                default:
                begin
                    batch.count    = 2'd3;
                    batch.items[0] = make_res(ebcc_pkg::RK_START, '0, '0, 1'b0, 1'b0);
                    batch.items[1] = make_res(ebcc_pkg::RK_PASS, frame.source,
                                              frame.frame_handle, mis, 1'b0);
                    batch.items[2] = make_res(ebcc_pkg::RK_END, '0, '0, 1'b0, 1'b1);
                end
            endcase
        end
    end

    // next event state
    always_comb
    begin
        pending_next = pending_reg;
        started_next = started_reg;
        seen_next    = seen_reg;
        if (accept)
        begin
            if (is_flush)
            begin
                pending_next = '0;
                started_next = 1'b0;
                seen_next    = '0;
            end
            else if (reject)
            begin
                pending_next = pend_eff;
            end
            else
            begin
                pending_next = pend_after;
                if (emit_end)
                begin
                    started_next = 1'b0;
                    seen_next    = '0;
                end
                else
                begin
                    started_next = started_reg | emit_start;
                    seen_next    = do_check ? (seen_reg | src_bit) : seen_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            started_reg <= 1'b0;
            seen_reg    <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            started_reg <= started_next;
            seen_reg    <= seen_next;
        end
    end

    // reference header, taken from the first checked frame of an event
    always_ff @(posedge clk)
    begin
        if (accept && !is_flush && !reject && do_check && is_ref)
        begin
            ref_type_reg   <= frame.hdr_type;
            ref_number_reg <= frame.event_number;
            ref_high_reg   <= frame.stamp_high;
            ref_mid_reg    <= frame.stamp_mid;
            ref_low_reg    <= frame.stamp_low;
        end
    end

    a_pending_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg & ~SRC_MASK) == '0)
        else $error("pending mask holds a source beyond the configured count");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_flush |=> pending_reg == '0 && !started_reg && seen_reg == '0)
        else $error("flush did not clear the event state");

    a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !is_flush && reject
        |=> seen_reg == $past(seen_reg) && started_reg == $past(started_reg))
        else $error("rejected frame changed the event state");

endmodule
`default_nettype wire

### hdl/ebcc_result_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ebcc_result_buf
// Holds the results of one request and hands them out one per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module ebcc_result_buf (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire ebcc_pkg::res_batch_t batch,
    output logic                      can_take,
    ebcc_result_if.source             results
);

    ebcc_pkg::result_t [ebcc_pkg::MAX_RES-1:0] slot_reg, slot_next;
    logic [ebcc_pkg::CNT_W-1:0]               cnt_reg, cnt_next;
    logic                                     pop;

    assign pop      = (cnt_reg != '0) && results.ready;
    assign can_take = (cnt_reg == '0) || (cnt_reg == 2'd1 && results.ready);

    assign results.valid   = (cnt_reg != '0);
    assign results.payload = slot_reg[0];

    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (pop)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (push)
        begin
            slot_next = batch.items;
            cnt_next  = batch.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg == '0 || (cnt_reg == 2'd1 && results.ready)))
        else $error("request taken while results still queued");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != '0 && !slot_reg[0].last) |-> cnt_reg >= 2'd2)
        else $error("result without last flag has no follower");

    a_last_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd1) |-> slot_reg[0].last)
        else $error("final queued result lacks last flag");

endmodule
`default_nettype wire

### verif/ebcc_build_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebcc_build_checker
// Watches the request, result and register ports of the event builder,
// predicts the results of every accepted request from its own copy of the
// event state and compares each delivered result field by field in order.
// ----------------------------------------------------------------------------
module ebcc_build_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    ebcc_frame_if                          frames,
    ebcc_result_if                         results,
    input  logic                           cfg_we,
    input  logic [ebcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ebcc_pkg::MASK_W-1:0]    cfg_data,
    output int unsigned                    backlog,
    output int unsigned                    errors
);

    logic [ebcc_pkg::MODE_W-1:0]  mode_reg;
    logic [ebcc_pkg::MASK_W-1:0]  active_reg;
    logic [ebcc_pkg::MASK_W-1:0]  pending_srcs;
    logic                         building;
    logic [ebcc_pkg::MASK_W-1:0]  checked_srcs;
    logic [ebcc_pkg::TYPE_W-1:0]  anchor_type;
    logic [ebcc_pkg::NUM_W-1:0]   anchor_number;
    logic [ebcc_pkg::STAMP_W-1:0] anchor_high;
    logic [ebcc_pkg::STAMP_W-1:0] anchor_mid;
    logic [ebcc_pkg::STAMP_W-1:0] anchor_low;
    ebcc_pkg::result_t            awaited_results[$];
    int unsigned                  fail_total = 0;

    function automatic ebcc_pkg::result_t result_of(
        input ebcc_pkg::rkind_t              k,
        input logic [ebcc_pkg::SRC_W-1:0]    s,
        input logic [ebcc_pkg::HANDLE_W-1:0] h,
        input logic                          mis
    );
        ebcc_pkg::result_t r;
        r.result_kind = k;
        r.out_source  = s;
        r.out_handle  = h;
        r.mismatch    = mis;
        r.last        = 1'b0;
        return r;
    endfunction

    task automatic clear_event_state();
        pending_srcs = '0;
        building     = 1'b0;
        checked_srcs = '0;
    endtask

    task automatic predict_build(input ebcc_pkg::frame_t f);
        ebcc_pkg::result_t           batch[$];
        ebcc_pkg::result_t           rej;
        logic [ebcc_pkg::MASK_W-1:0] src_bit;
        logic                        mis;
        logic [31:0]                 stamp;
        logic [31:0]                 anchor_stamp;
        mis = 1'b0;
        if (f.kind == ebcc_pkg::KIND_FLUSH)
        begin
            clear_event_state();
            return;
        end
        if (pending_srcs == '0)
            pending_srcs = active_reg;
        src_bit = {{(ebcc_pkg::MASK_W-1){1'b0}}, 1'b1} << f.source;
        if ((pending_srcs & src_bit) == '0)
        begin
            rej = result_of(ebcc_pkg::RK_REJECT, f.source, f.frame_handle, 1'b0);
            rej.last = 1'b1;
            awaited_results.push_back(rej);
            return;
        end
        if (mode_reg[ebcc_pkg::MODE_MARKERS] && !building)
        begin
            batch.push_back(result_of(ebcc_pkg::RK_START, '0, '0, 1'b0));
            building = 1'b1;
        end
        if (mode_reg[ebcc_pkg::MODE_NEAR:ebcc_pkg::MODE_NUMBER] != '0
            && (checked_srcs & src_bit) == '0)
        begin
            if (checked_srcs == '0)
            begin
                anchor_type   = f.hdr_type;
                anchor_number = f.event_number;
                anchor_high   = f.stamp_high;
                anchor_mid    = f.stamp_mid;
                anchor_low    = f.stamp_low;
            end
            else
            begin
                if (mode_reg[ebcc_pkg::MODE_NUMBER] &&
                    (anchor_type != f.hdr_type || anchor_number != f.event_number))
                    mis = 1'b1;
                if (mode_reg[ebcc_pkg::MODE_EXACT] &&
                    {anchor_high, anchor_mid, anchor_low} !=
                    {f.stamp_high, f.stamp_mid, f.stamp_low})
                    mis = 1'b1;
                if (mode_reg[ebcc_pkg::MODE_NEAR])
                begin
                    stamp        = {f.stamp_mid, f.stamp_low};
                    anchor_stamp = {anchor_mid, anchor_low};
                    if (anchor_high != f.stamp_high && stamp != 32'h0000_0000 &&
                        stamp != 32'hFFFF_FFFF)
                        mis = 1'b1;
                    if (anchor_stamp != stamp && anchor_stamp != stamp + 32'd1 &&
                        anchor_stamp != stamp - 32'd1)
                        mis = 1'b1;
                end
            end
            checked_srcs |= src_bit;
        end
        batch.push_back(result_of(ebcc_pkg::RK_PASS, f.source, f.frame_handle, mis));
        if (f.end_of_event)
            pending_srcs &= ~src_bit;
        if (mode_reg[ebcc_pkg::MODE_MARKERS] && pending_srcs == '0)
        begin
            batch.push_back(result_of(ebcc_pkg::RK_END, '0, '0, 1'b0));
            building     = 1'b0;
            checked_srcs = '0;
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            awaited_results.push_back(batch[i]);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fail_total++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    task automatic compare_result(input ebcc_pkg::result_t got);
        ebcc_pkg::result_t want;
        if (awaited_results.size() == 0)
        begin
            fail_total++;
            $display("%0t: result with nothing expected, actual kind %0d source %0d handle %0d",
                     $time, got.result_kind, got.out_source, got.out_handle);
            return;
        end
        want = awaited_results.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
        check_field("out_source", 32'(want.out_source), 32'(got.out_source));
        check_field("out_handle", 32'(want.out_handle), 32'(got.out_handle));
        check_field("mismatch", 32'(want.mismatch), 32'(got.mismatch));
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      = '0;
            active_reg    = '0;
            anchor_type   = '0;
            anchor_number = '0;
            anchor_high   = '0;
            anchor_mid    = '0;
            anchor_low    = '0;
            clear_event_state();
            awaited_results.delete();
        end
        else
        begin
            if (results.valid && results.ready)
                compare_result(results.payload);
            if (cfg_we)
            begin
                if (cfg_index == ebcc_pkg::CFG_BUILD_MODE)
                    mode_reg = cfg_data[ebcc_pkg::MODE_W-1:0];
                else
                    active_reg = cfg_data;
            end
            if (frames.valid && frames.ready)
                predict_build(frames.payload);
        end
        backlog <= awaited_results.size();
        errors  <= fail_total;
    end

endmodule

### verif/event_builder_consistency_check_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_builder_consistency_check_unit_test
// Drives frame and flush requests into the event builder under a series of
// build modes and source sets: a directed run over markers, rejects, flushes
// and timestamp wrap, then random events with noise, idle gaps, result stalls
// and one long result hold-off.
// ----------------------------------------------------------------------------
module event_builder_consistency_check_unit_test;

    localparam int unsigned LONG_HOLD = 80;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [ebcc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ebcc_pkg::MASK_W-1:0]    cfg_data;
    int unsigned                    backlog;
    int unsigned                    errors;
    int unsigned                    idle_pct = 0;
    int unsigned                    stall_pct = 0;
    logic                           hold_go;
    int unsigned                    sent = 0;

    ebcc_frame_if  frames_ch();
    ebcc_result_if results_ch();

    event_builder_consistency_check_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ebcc_build_checker build_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .frames    (frames_ch),
        .results   (results_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .backlog   (backlog),
        .errors    (errors)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result side: random stalls plus one long hold-off
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        results_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go)
            begin
                hold_left = LONG_HOLD;
                results_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left--;
                results_ch.ready <= 1'b0;
            end
            else
                results_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        #4_000_000;
        $display("event_builder_consistency_check_unit verification failed");
        $finish;
    end

    function automatic ebcc_pkg::frame_t frame_of(
        input logic                         k,
        input logic [ebcc_pkg::SRC_W-1:0]   s,
        input logic                         eoe,
        input logic [ebcc_pkg::TYPE_W-1:0]  ty,
        input logic [ebcc_pkg::NUM_W-1:0]   nb,
        input logic [ebcc_pkg::STAMP_W-1:0] th,
        input logic [31:0]                  stamp
    );
        ebcc_pkg::frame_t f;
        f.kind         = k;
        f.source       = s;
        f.frame_handle = ebcc_pkg::HANDLE_W'($urandom);
        f.end_of_event = eoe;
        f.hdr_type     = ty;
        f.event_number = nb;
        f.stamp_high   = th;
        {f.stamp_mid, f.stamp_low} = stamp;
        return f;
    endfunction

    function automatic ebcc_pkg::frame_t random_frame();
        return frame_of(ebcc_pkg::KIND_FRAME, ebcc_pkg::SRC_W'($urandom), 1'($urandom),
                        ebcc_pkg::TYPE_W'($urandom), $urandom,
                        ebcc_pkg::STAMP_W'($urandom), $urandom);
    endfunction

    function automatic ebcc_pkg::frame_t event_header();
        ebcc_pkg::frame_t h;
        h = random_frame();
        case ($urandom_range(5))
            0: {h.stamp_mid, h.stamp_low} = 32'hFFFF_FFFF;
            1: {h.stamp_mid, h.stamp_low} = 32'h0000_0000;
            default: ;
        endcase
        return h;
    endfunction

    // header of one source, mostly close to the event header
    function automatic ebcc_pkg::frame_t variant_of(input ebcc_pkg::frame_t base);
        ebcc_pkg::frame_t v;
        logic [31:0]      stamp;
        v = base;
        stamp = {base.stamp_mid, base.stamp_low};
        case ($urandom_range(13))
            0: v.hdr_type = ebcc_pkg::TYPE_W'($urandom);
            1: v.event_number = base.event_number + 32'd1;
            2: stamp = stamp + 32'd1;
            3: stamp = stamp - 32'd1;
            4: stamp = stamp + 32'd2;
            5: stamp = stamp - 32'd2;
            6: v.stamp_high = base.stamp_high + 16'd1;
            7:
            begin
                v.stamp_high = base.stamp_high + 16'd1;
                stamp = stamp + 32'd1;
            end
            8: stamp = $urandom;
            default: ;
        endcase
        {v.stamp_mid, v.stamp_low} = stamp;
        v.frame_handle = ebcc_pkg::HANDLE_W'($urandom);
        return v;
    endfunction

    function automatic logic [ebcc_pkg::MASK_W-1:0] rand_sources();
        logic [ebcc_pkg::MASK_W-1:0] m;
        m = '0;
        repeat ($urandom_range(1, 4))
            m[$urandom_range(31)] = 1'b1;
        return m;
    endfunction

    task automatic push_request(input ebcc_pkg::frame_t f);
        while ($urandom_range(99) < idle_pct)
        begin
            frames_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frames_ch.valid   <= 1'b1;
        frames_ch.payload <= f;
        do
            @(posedge clk);
        while (!frames_ch.ready);
        sent++;
    endtask

    task automatic settle();
        frames_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (backlog != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [ebcc_pkg::MODE_W-1:0] mode,
                               input logic [ebcc_pkg::MASK_W-1:0] act);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= ebcc_pkg::CFG_BUILD_MODE;
        cfg_data  <= ebcc_pkg::MASK_W'(mode);
        @(posedge clk);
        cfg_index <= ebcc_pkg::CFG_ACTIVE_SOURCES;
        cfg_data  <= act;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_events(input int unsigned quota,
                              input logic [ebcc_pkg::MASK_W-1:0] act);
        int unsigned                 target;
        int unsigned                 r;
        logic [ebcc_pkg::MASK_W-1:0] left;
        logic [ebcc_pkg::SRC_W-1:0]  pick;
        ebcc_pkg::frame_t            base;
        ebcc_pkg::frame_t            f;
        target = sent + quota;
        left = '0;
        base = event_header();
        while (sent < target)
        begin
            if (left == '0)
            begin
                left = act;
                base = event_header();
                if (act == '0)
                    push_request(random_frame());
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 3)
                begin
                    f = random_frame();
                    f.kind = ebcc_pkg::KIND_FLUSH;
                    push_request(f);
                    left = '0;
                end
                else if (r < 10)
                    push_request(random_frame());
                else
                begin
                    pick = ebcc_pkg::SRC_W'($urandom);
                    while (!left[pick])
                        pick = pick + 1'b1;
                    f = variant_of(base);
                    f.source = pick;
                    f.end_of_event = ($urandom_range(2) == 0);
                    push_request(f);
                    if (f.end_of_event)
                        left[pick] = 1'b0;
                end
            end
        end
    endtask

    task automatic run_phase(input logic [ebcc_pkg::MODE_W-1:0] mode,
                             input logic [ebcc_pkg::MASK_W-1:0] act,
                             input int unsigned quota, input int unsigned idle,
                             input int unsigned stall, input logic squeeze);
        reconfigure(mode, act);
        idle_pct = idle;
        stall_pct <= stall;
        if (squeeze)
        begin
            hold_go <= 1'b1;
            @(posedge clk);
            hold_go <= 1'b0;
        end
        run_events(quota, act);
    endtask

    initial
    begin
        int unsigned guard;
        rst_n             <= 1'b0;
        frames_ch.valid   <= 1'b0;
        frames_ch.payload <= '0;
        cfg_we            <= 1'b0;
        cfg_index         <= ebcc_pkg::CFG_BUILD_MODE;
        cfg_data          <= '0;
        hold_go           <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty source set after reset
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b0, '0, '0, '0, 32'h0));

        // markers and all checks, sources 0, 1 and 31
        reconfigure(4'hF, 32'h8000_0003);
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF,
                              16'hFFFF, 32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd2, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                              16'hFFFF, 32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                              16'hFFFF, 32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd31, 1'b1, 16'hFFFF, 32'h0,
                              16'hFFFF, 32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b1, 16'h0, 32'h0, 16'h0,
                              32'h0));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd1, 1'b0, 16'h0, 32'h0, 16'h0,
                              32'h0));
        push_request(frame_of(ebcc_pkg::KIND_FLUSH, 5'd31, 1'b1, 16'hFFFF, 32'hFFFF_FFFF,
                              16'hFFFF, 32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd31, 1'b1, 16'h1234, 32'h1, 16'h2,
                              32'h3));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b1, 16'h1234, 32'h1, 16'h2,
                              32'h4));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd1, 1'b1, 16'h1234, 32'h1, 16'h2,
                              32'h3));

        // plus or minus one timestamp check across the wrap
        reconfigure(4'h9, 32'h0000_0007);
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b1, 16'h1, 32'h1, 16'h5,
                              32'hFFFF_FFFF));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd1, 1'b1, 16'h2, 32'h2, 16'h6,
                              32'h0000_0000));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd2, 1'b1, 16'h1, 32'h1, 16'h5,
                              32'hFFFF_FFFD));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd0, 1'b1, 16'h1, 32'h1, 16'h7,
                              32'h0000_0001));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd1, 1'b1, 16'h1, 32'h1, 16'h8,
                              32'h0000_0002));
        push_request(frame_of(ebcc_pkg::KIND_FRAME, 5'd2, 1'b1, 16'h1, 32'h1, 16'h7,
                              32'h0000_0000));

        run_phase(4'hF, rand_sources(), 50, 0, 0, 1'b0);
        run_phase(4'h1, rand_sources(), 50, 63, 0, 1'b0);
        run_phase(4'hB, rand_sources(), 50, 0, 63, 1'b0);
        run_phase(4'h5, rand_sources(), 50, 16, 16, 1'b0);
        run_phase(4'h0, 32'hFFFF_FFFF, 40, 0, 0, 1'b0);
        run_phase(4'hF, 32'hFFFF_FFFF, 50, 16, 16, 1'b0);
        run_phase(4'h9, rand_sources(), 40, 0, 0, 1'b1);
        run_phase(4'hE, 32'h0000_0000, 20, 0, 0, 1'b0);
        run_phase(4'h3, rand_sources(), 20, 63, 63, 1'b0);

        frames_ch.valid <= 1'b0;
        guard = 0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (backlog != 0 && guard < 20000);
        repeat (10) @(posedge clk);
        if (errors == 0 && backlog == 0)
            $display("event_builder_consistency_check_unit verification clean");
        else
            $display("event_builder_consistency_check_unit verification failed");
        $finish;
    end

endmodule
